>>> src/bcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_pkg
// Shared types and constants for the battery cadence policy block.
// ----------------------------------------------------------------------------
package bcp_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [14:0] STEADY_BAND_MV = 15'd20;
  localparam logic [31:0] MAX_TIME       = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    MODE_NORMAL    = 3'd0,
    MODE_FAST      = 3'd1,
    MODE_SETTLING  = 3'd2,
    MODE_LOW       = 3'd3,
    MODE_DEEP      = 3'd4,
    MODE_LONG_IDLE = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    REG_CHARGER_RISE  = 3'd0,
    REG_FAST_DUR      = 3'd1,
    REG_SETTLING_DUR  = 3'd2,
    REG_DEEP_DROP     = 3'd3,
    REG_LOW_DROP      = 3'd4,
    REG_DEEP_FLOOR    = 3'd5,
    REG_LOW_FLOOR     = 3'd6,
    REG_LONG_IDLE     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] rise_mv;
    logic [19:0] fast_duration_s;
    logic [19:0] settling_duration_s;
    logic [14:0] deep_drop_mv;
    logic [14:0] low_drop_mv;
    logic [14:0] deep_floor_mv;
    logic [14:0] low_floor_mv;
    logic [23:0] idle_after_s;
  } cfg_t;

  typedef struct packed {
    logic [14:0] batt_mv;
    logic        ignition;
    logic [31:0] now_s;
  } obs_t;

  typedef struct packed {
    mode_t mode;
    logic  new_session;
    logic  significant_change;
  } res_t;

  // saturating 32-bit add of a 20-bit duration
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [19:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {13'd0, b};
    return s[32] ? MAX_TIME : s[31:0];
  endfunction

endpackage
`default_nettype wire

>>> src/bcp_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_regs
// APB register file holding the policy thresholds and durations.
// ----------------------------------------------------------------------------
module bcp_regs import bcp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_mv             <= 15'd300;
      cfg.fast_duration_s     <= 20'd600;
      cfg.settling_duration_s <= 20'd1800;
      cfg.deep_drop_mv        <= 15'd800;
      cfg.low_drop_mv         <= 15'd400;
      cfg.deep_floor_mv       <= 15'd0;
      cfg.low_floor_mv        <= 15'd0;
      cfg.idle_after_s        <= 24'd86400;
    end else if (wr) begin
      unique case (idx)
        REG_CHARGER_RISE: cfg.rise_mv             <= pwdata[14:0];
        REG_FAST_DUR:     cfg.fast_duration_s     <= pwdata[19:0];
        REG_SETTLING_DUR: cfg.settling_duration_s <= pwdata[19:0];
        REG_DEEP_DROP:    cfg.deep_drop_mv        <= pwdata[14:0];
        REG_LOW_DROP:     cfg.low_drop_mv         <= pwdata[14:0];
        REG_DEEP_FLOOR:   cfg.deep_floor_mv       <= pwdata[14:0];
        REG_LOW_FLOOR:    cfg.low_floor_mv        <= pwdata[14:0];
        REG_LONG_IDLE:    cfg.idle_after_s        <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CHARGER_RISE: prdata = {17'd0, cfg.rise_mv};
      REG_FAST_DUR:     prdata = {12'd0, cfg.fast_duration_s};
      REG_SETTLING_DUR: prdata = {12'd0, cfg.settling_duration_s};
      REG_DEEP_DROP:    prdata = {17'd0, cfg.deep_drop_mv};
      REG_LOW_DROP:     prdata = {17'd0, cfg.low_drop_mv};
      REG_DEEP_FLOOR:   prdata = {17'd0, cfg.deep_floor_mv};
      REG_LOW_FLOOR:    prdata = {17'd0, cfg.low_floor_mv};
      REG_LONG_IDLE:    prdata = {8'd0, cfg.idle_after_s};
    endcase
  end

endmodule
`default_nettype wire

>>> src/bcp_policy.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_policy
// Tracking state and single-pass mode decision for one observation.
// ----------------------------------------------------------------------------
module bcp_policy import bcp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic fire,
  input  wire obs_t obs,
  output res_t      res
);

  logic        started;
  logic [14:0] prev_voltage;
  logic [14:0] ref_voltage;
  logic [31:0] last_charge_time;
  logic [31:0] fast_deadline;
  logic [31:0] settle_deadline;

  logic [14:0] ref_voltage_next;
  logic [31:0] last_charge_time_next;
  logic [31:0] fast_deadline_next;
  logic [31:0] settle_deadline_next;

  logic        up;
  logic [14:0] mag;
  logic        sig;
  logic        charger;
  logic [31:0] fast_new;
  logic [14:0] drop;
  logic        deep;
  logic        low;
  logic [31:0] idle_s;
  mode_t       mode;

  always_comb begin
    up       = obs.batt_mv >= prev_voltage;
    mag      = up ? obs.batt_mv - prev_voltage : prev_voltage - obs.batt_mv;
    sig      = mag >= cfg.rise_mv;
    charger  = !obs.ignition && up && sig && (obs.now_s >= settle_deadline);
    fast_new = sat_add(obs.now_s, cfg.fast_duration_s);

    fast_deadline_next    = charger ? fast_new : fast_deadline;
    settle_deadline_next  = charger ? sat_add(fast_new, cfg.settling_duration_s)
                                    : settle_deadline;
    last_charge_time_next = charger ? obs.now_s : last_charge_time;
    ref_voltage_next      = (charger || obs.batt_mv > ref_voltage) ? obs.batt_mv
                                                                   : ref_voltage;

    // reference never sits below the current voltage here
    drop = ref_voltage_next - obs.batt_mv;
    deep = (drop >= cfg.deep_drop_mv) ||
           ((cfg.deep_floor_mv != 15'd0) && (obs.batt_mv <= cfg.deep_floor_mv));
    low  = (drop >= cfg.low_drop_mv) ||
           ((cfg.low_floor_mv != 15'd0) && (obs.batt_mv <= cfg.low_floor_mv));
    idle_s = obs.now_s - last_charge_time_next;

    priority if (!obs.ignition && deep) begin
      mode = MODE_DEEP;
    end else if (!obs.ignition && low) begin
      mode = MODE_LOW;
    end else if (obs.now_s < fast_deadline_next) begin
      mode = MODE_FAST;
    end else if ((obs.now_s < settle_deadline_next) && (mag > STEADY_BAND_MV)) begin
      mode = MODE_SETTLING;
    end else if (!obs.ignition && (obs.now_s >= last_charge_time_next) &&
                 (idle_s >= {8'd0, cfg.idle_after_s})) begin
      mode = MODE_LONG_IDLE;
    end else begin
      mode = MODE_NORMAL;
    end

    if (!started) begin
      res.mode               = MODE_NORMAL;
      res.new_session        = 1'b0;
      res.significant_change = 1'b0;
    end else begin
      res.mode               = mode;
      res.new_session        = charger;
      res.significant_change = sig;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started          <= 1'b0;
      prev_voltage     <= '0;
      ref_voltage      <= '0;
      last_charge_time <= '0;
      fast_deadline    <= '0;
      settle_deadline  <= '0;
    end else if (fire) begin
      started      <= 1'b1;
      prev_voltage <= obs.batt_mv;
      if (!started) begin
        // first word only seeds the trackers
        ref_voltage      <= obs.batt_mv;
        last_charge_time <= obs.now_s;
      end else begin
        ref_voltage      <= ref_voltage_next;
        last_charge_time <= last_charge_time_next;
        fast_deadline    <= fast_deadline_next;
        settle_deadline  <= settle_deadline_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/battery_cadence_policy.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: observation word -> input register s1 -> result register res.
// Throughput: one word per cycle unless res_ready is low; the input and result
//   registers let a new word in while the previous result waits on res_ready.
// Reset: synchronous, active high; clears tracking state, pipeline valids and
//   loads the register defaults.
// ----------------------------------------------------------------------------
// battery_cadence_policy
// Picks a reporting cadence mode per battery observation and flags charger
// sessions and significant voltage steps.
// ----------------------------------------------------------------------------
module battery_cadence_policy import bcp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // observation channel
  input  wire logic              obs_valid,
  output logic                   obs_ready,
  input  wire obs_t              obs,
  // result channel
  output logic                   res_valid,
  input  wire logic              res_ready,
  output res_t                   res,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;

  // input register
  logic s1_valid;
  obs_t s1_obs;

  // result register slot is free, or is emptied this cycle
  logic advance;
  logic fire;
  res_t res_comb;

  assign advance   = !res_valid || res_ready;
  assign obs_ready = !s1_valid || advance;
  // state moves forward exactly when an observation word leaves s1
  assign fire      = s1_valid && advance;

  bcp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcp_policy u_policy (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .obs  (s1_obs),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (obs_valid && obs_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (obs_valid && obs_ready) begin
      s1_obs <= obs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_comb;
    end
  end

endmodule
`default_nettype wire

>>> src/bcp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_checker
// Port-level checks on the cadence policy, bound to the top level.
// ----------------------------------------------------------------------------
module bcp_checker import bcp_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic obs_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire res_t res
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // with the result slot empty the pipe always takes a word
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> obs_ready)
    else $error("input stalled with empty result slot");

  // a charger needs a rise at least the significant threshold
  a_charger_sig: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.new_session |-> res.significant_change)
    else $error("charger without significant change");

endmodule

bind battery_cadence_policy bcp_checker u_bcp_checker (
  .clk       (clk),
  .rst       (rst),
  .obs_ready (obs_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for battery_cadence_policy. Observation words go in
// through valid/ready with random gaps; an in-bench cadence predictor works out
// each result word, and a checker compares every result word by field.
// ----------------------------------------------------------------------------
module tb;
  import bcp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SHOW_MAX    = 10;

  // register values loaded by reset
  localparam cfg_t CFG_DEFAULT = '{
    rise_mv:             15'd300,
    fast_duration_s:     20'd600,
    settling_duration_s: 20'd1800,
    deep_drop_mv:        15'd800,
    low_drop_mv:         15'd400,
    deep_floor_mv:       15'd0,
    low_floor_mv:        15'd0,
    idle_after_s:        24'd86400
  };

  // --------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              obs_valid = 1'b0;
  logic              obs_ready;
  obs_t              obs_word  = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  res_t              res_word;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  battery_cadence_policy u_top (
    .clk       (clk),
    .rst       (rst),
    .obs_valid (obs_valid),
    .obs_ready (obs_ready),
    .obs       (obs_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Cadence predictor state: a private copy of the tracking state and of the
  // registers, advanced once per accepted observation word.
  // --------------------------------------------------------------------------
  cfg_t        cfg_m      = CFG_DEFAULT;
  logic        seen_first = 1'b0;
  logic [14:0] last_mv    = '0;
  logic [14:0] ref_mv     = '0;
  logic [31:0] charge_ts  = '0;
  logic [31:0] fast_ts    = '0;
  logic [31:0] settle_ts  = '0;

  res_t        want_q[$];   // predicted result words, oldest first
  res_t        want_w;
  int          fail_cnt   = 0;
  int          cycle_cnt  = 0;

  // traffic shaping
  logic        quiet      = 1'b0;  // no gaps on either side while set
  int          ready_hold = 0;
  int          stall_len;
  int          phase_sent;
  logic [31:0] trip_ts    = '0;    // timeline carried between trips

  // 32-bit add clamped at the top of the time range
  function automatic logic [31:0] add_clamp(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic res_t cadence_step(input obs_t o);
    res_t        r;
    int          delta;
    logic [14:0] mag;
    logic [14:0] drop;
    logic        sig;
    logic        chg;
    logic        deep_hit;
    logic        low_hit;
    r.mode               = MODE_NORMAL;
    r.new_session        = 1'b0;
    r.significant_change = 1'b0;
    // first word only seeds the tracking state
    if (!seen_first) begin
      seen_first = 1'b1;
      last_mv    = o.batt_mv;
      ref_mv     = o.batt_mv;
      charge_ts  = o.now_s;
      return r;
    end
    delta = int'(o.batt_mv) - int'(last_mv);
    mag   = (delta < 0) ? 15'(-delta) : 15'(delta);
    sig   = (mag >= cfg_m.rise_mv);
    chg   = !o.ignition && (delta >= 0) && (mag >= cfg_m.rise_mv) &&
            (o.now_s >= settle_ts);
    if (chg) begin
      charge_ts = o.now_s;
      fast_ts   = add_clamp(o.now_s, {12'd0, cfg_m.fast_duration_s});
      settle_ts = add_clamp(fast_ts, {12'd0, cfg_m.settling_duration_s});
    end
    // reference only climbs, except a new charge session always reloads it
    if (chg || (o.batt_mv > ref_mv))
      ref_mv = o.batt_mv;
    drop     = ref_mv - o.batt_mv;
    deep_hit = (drop >= cfg_m.deep_drop_mv) ||
               ((cfg_m.deep_floor_mv != 0) && (o.batt_mv <= cfg_m.deep_floor_mv));
    low_hit  = (drop >= cfg_m.low_drop_mv) ||
               ((cfg_m.low_floor_mv != 0) && (o.batt_mv <= cfg_m.low_floor_mv));
    if (!o.ignition && deep_hit)
      r.mode = MODE_DEEP;
    else if (!o.ignition && low_hit)
      r.mode = MODE_LOW;
    else if (o.now_s < fast_ts)
      r.mode = MODE_FAST;
    else if ((o.now_s < settle_ts) && (mag > STEADY_BAND_MV))
      r.mode = MODE_SETTLING;
    else if (!o.ignition && (o.now_s >= charge_ts) &&
             ((o.now_s - charge_ts) >= {8'd0, cfg_m.idle_after_s}))
      r.mode = MODE_LONG_IDLE;  // clock running backwards never gets here
    last_mv              = o.batt_mv;
    r.new_session        = chg;
    r.significant_change = sig;
    return r;
  endfunction

  function automatic void note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= SHOW_MAX)
      $display("[%0t] %s", $time, msg);
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic obs_t mk_obs(input int v, input logic ign, input logic [31:0] t);
    obs_t o;
    o.batt_mv  = 15'(v);
    o.ignition = ign;
    o.now_s    = t;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, then field-by-field check against the
  // oldest prediction.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (quiet) begin
      res_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (res_ready) begin
      stall_len = rand_gap();
      if (stall_len > 0) begin
        res_ready  <= 1'b0;
        ready_hold <= stall_len - 1;
      end else begin
        ready_hold <= $urandom_range(0, 12);
      end
    end else begin
      res_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (want_q.size() == 0) begin
        note_fail($sformatf("result word with none pending: mode=%0d chg=%0b sig=%0b",
                            res_word.mode, res_word.new_session,
                            res_word.significant_change));
      end else begin
        want_w = want_q.pop_front();
        if (res_word.mode !== want_w.mode)
          note_fail($sformatf("mode: exp %0d got %0d", want_w.mode, res_word.mode));
        if (res_word.new_session !== want_w.new_session)
          note_fail($sformatf("new_session: exp %0b got %0b",
                              want_w.new_session, res_word.new_session));
        if (res_word.significant_change !== want_w.significant_change)
          note_fail($sformatf("significant_change: exp %0b got %0b",
                              want_w.significant_change, res_word.significant_change));
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Observation side. valid stays up after a word is taken until the next
  // falling edge, where either the next word or a gap replaces it.
  // --------------------------------------------------------------------------
  task automatic send_obs(input obs_t o);
    int gap;
    gap = quiet ? 0 : rand_gap();
    repeat (gap) begin
      @(negedge clk);
      obs_valid <= 1'b0;
    end
    @(negedge clk);
    obs_valid <= 1'b1;
    obs_word  <= o;
    do @(posedge clk); while (!obs_ready);
    want_q.push_back(cadence_step(o));
  endtask

  // drop valid, let every pending result word drain, then a few spare cycles
  task automatic wait_idle();
    @(negedge clk);
    obs_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, done on the edge with pready high
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CHARGER_RISE: cfg_m.rise_mv             = val[14:0];
      REG_FAST_DUR:     cfg_m.fast_duration_s     = val[19:0];
      REG_SETTLING_DUR: cfg_m.settling_duration_s = val[19:0];
      REG_DEEP_DROP:    cfg_m.deep_drop_mv        = val[14:0];
      REG_LOW_DROP:     cfg_m.low_drop_mv         = val[14:0];
      REG_DEEP_FLOOR:   cfg_m.deep_floor_mv       = val[14:0];
      REG_LOW_FLOOR:    cfg_m.low_floor_mv        = val[14:0];
      REG_LONG_IDLE:    cfg_m.idle_after_s        = val[23:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(input cfg_t c);
    write_reg(REG_CHARGER_RISE, 32'(c.rise_mv));
    write_reg(REG_FAST_DUR,     32'(c.fast_duration_s));
    write_reg(REG_SETTLING_DUR, 32'(c.settling_duration_s));
    write_reg(REG_DEEP_DROP,    32'(c.deep_drop_mv));
    write_reg(REG_LOW_DROP,     32'(c.low_drop_mv));
    write_reg(REG_DEEP_FLOOR,   32'(c.deep_floor_mv));
    write_reg(REG_LOW_FLOOR,    32'(c.low_floor_mv));
    write_reg(REG_LONG_IDLE,    32'(c.idle_after_s));
  endtask

  // settings a real pack would plausibly use; floors on about half the time
  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.rise_mv             = 15'($urandom_range(20, 600));
    c.fast_duration_s     = ($urandom_range(0, 9) == 0) ? 20'd0 :
                            20'($urandom_range(1, 3000));
    c.settling_duration_s = 20'($urandom_range(0, 5000));
    c.deep_drop_mv        = 15'($urandom_range(300, 1500));
    c.low_drop_mv         = 15'($urandom_range(50, 1200));
    c.deep_floor_mv       = $urandom_range(0, 1) ? 15'd0 : 15'($urandom_range(9000, 11500));
    c.low_floor_mv        = $urandom_range(0, 1) ? 15'd0 : 15'($urandom_range(11000, 12800));
    c.idle_after_s        = 24'($urandom_range(100, 200000));
    return c;
  endfunction

  // One trip: a run of plausible observations with time moving forward in
  // steps sized to the current windows, salted with stray words.
  task automatic drive_trip();
    int          len;
    int          r;
    int          v;
    int          step;
    logic        ign;
    logic [32:0] t;
    obs_t        o;
    len   = $urandom_range(5, 40);
    quiet = ($urandom_range(0, 4) == 0);
    v     = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) :
                                          $urandom_range(11000, 14500);
    ign   = $urandom_range(0, 1);
    // start past the settling window so a charger can show up again
    t = {1'b0, trip_ts};
    if (settle_ts > t[31:0]) t = {1'b0, settle_ts};
    if (charge_ts > t[31:0]) t = {1'b0, charge_ts};
    t = t + 33'($urandom_range(0, 100));
    if (t[32]) t = {1'b0, 32'hFFFF_FFFF};
    for (int k = 0; k < len; k++) begin
      phase_sent++;
      if ($urandom_range(0, 99) < 8) begin
        // stray word anywhere in the field ranges; high times with ignition
        // off would push the deadlines out of reach for the rest of the run
        o.batt_mv  = 15'($urandom_range(0, 32767));
        o.ignition = $urandom_range(0, 1);
        o.now_s    = $urandom();
        if (o.now_s >= 32'hC000_0000) o.ignition = 1'b1;
        send_obs(o);
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        v = v + $urandom_range(0, 50) - 25;       // resting, around the stable band
      end else if (r < 70) begin
        v = v + cfg_m.rise_mv + $urandom_range(0, 400);
        ign = 1'b0;                                // charger plugged in, parked
      end else if (r < 85) begin
        v = v - $urandom_range(0, cfg_m.deep_drop_mv + 200);
      end else begin
        ign = !ign;
        v = v + $urandom_range(0, 400) - 200;
      end
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      r = $urandom_range(0, 99);
      if (r < 5)
        step = 0;
      else if (r < 60)
        step = $urandom_range(1, 40);
      else if (r < 85)
        step = $urandom_range(1, cfg_m.fast_duration_s + cfg_m.settling_duration_s + 10);
      else if (r < 95)
        step = $urandom_range(1, cfg_m.idle_after_s + 2000);
      else
        step = -$urandom_range(0, 1000);           // clock stepping back
      if (step < 0)
        t = (t > 33'(-step)) ? t - 33'(-step) : 33'd0;
      else
        t = t + 33'(step);
      if (t[32]) t = {1'b0, 32'hFFFF_FFFF};
      send_obs(mk_obs(v, ign, t[31:0]));
    end
    trip_ts = t[31:0];
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_first_observation();
    // seeds state only; reports normal whatever the voltage jump
    send_obs(mk_obs(12000, 1'b0, 32'd1000));
  endtask

  task automatic test_cadence_modes();
    send_obs(mk_obs(12400, 1'b0, 32'd1010));    // rise past threshold: charger, fast
    send_obs(mk_obs(12410, 1'b1, 32'd1100));    // still inside fast window
    send_obs(mk_obs(12390, 1'b0, 32'd2000));    // step of exactly the stable band
    send_obs(mk_obs(12369, 1'b0, 32'd2010));    // one past it: settling
    send_obs(mk_obs(11969, 1'b0, 32'd2030));    // low drop
    send_obs(mk_obs(11500, 1'b0, 32'd2040));    // deep drop
    send_obs(mk_obs(11500, 1'b1, 32'd2050));    // ignition masks deep/low
    send_obs(mk_obs(12000, 1'b0, 32'd100000));  // second charge session
    send_obs(mk_obs(12000, 1'b0, 32'd200000));  // long idle
    send_obs(mk_obs(12000, 1'b0, 32'd150000));  // clock runs backwards
    send_obs(mk_obs(0,     1'b0, 32'd150010));  // bottom of voltage range
    send_obs(mk_obs(32767, 1'b1, 32'd150020));  // top, ignition on: no charger
  endtask

  task automatic test_zero_thresholds();
    wait_idle();
    load_cfg('0);
    // zero drops: deep whenever ignition is off; zero rise: flat is a charger
    send_obs(mk_obs(12000, 1'b0, 32'd160000));
    send_obs(mk_obs(12000, 1'b0, 32'd160001));
    send_obs(mk_obs(12000, 1'b1, 32'd160002));
  endtask

  task automatic test_max_thresholds();
    wait_idle();
    load_cfg('1);
    // full-scale floors and rise
    send_obs(mk_obs(0,     1'b0, 32'd170000));
    send_obs(mk_obs(32767, 1'b0, 32'd170001));
    send_obs(mk_obs(32767, 1'b1, 32'd170002));
    send_obs(mk_obs(0,     1'b1, 32'd170003));
  endtask

  task automatic test_random_traffic();
    cfg_t c;
    int   quota;
    for (int ph = 0; ph < 8; ph++) begin
      quota = 270;
      case (ph)
        0:       c = CFG_DEFAULT;
        3:       begin c = '0; quota = 120; end
        6:       begin c = '1; quota = 120; end
        default: c = rand_cfg();
      endcase
      wait_idle();
      load_cfg(c);
      phase_sent = 0;
      while (phase_sent < quota) begin
        drive_trip();
        // now and then hold the sender back until the pipe is empty
        if ($urandom_range(0, 7) == 0) wait_idle();
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_deadline_saturation();
    wait_idle();
    load_cfg(CFG_DEFAULT);
    // charge right at the top of time: both deadline sums clamp
    send_obs(mk_obs(10000, 1'b1, 32'hFFFF_FF00));
    send_obs(mk_obs(10500, 1'b0, 32'hFFFF_FF01));
    send_obs(mk_obs(10500, 1'b0, 32'hFFFF_FFFF));
    send_obs(mk_obs(10900, 1'b0, 32'hFFFF_FFFF));
    send_obs(mk_obs(10900, 1'b0, 32'd5));
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_first_observation();
    test_cadence_modes();
    test_zero_thresholds();
    test_max_thresholds();
    test_random_traffic();
    test_deadline_saturation();
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && want_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
